>>> sv/uetu_pkg.sv
// Package with the word types and character constants of the escape to UTF-8 encoder.
package uetu_pkg;

  typedef struct packed {
    logic [7:0]  char_byte;
    logic        start_req;
    logic [15:0] space_left;
  } in_word_t;

  typedef struct packed {
    logic [3:0] consumed;
    logic [2:0] byte_count;
    logic [7:0] utf8_byte0;
    logic [7:0] utf8_byte1;
    logic [7:0] utf8_byte2;
    logic [7:0] utf8_byte3;
  } out_word_t;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLowerU    = 8'h75;
  localparam logic [7:0] CharUpperU    = 8'h55;

  localparam logic [3:0] PosBackslash  = 4'd0;
  localparam logic [3:0] PosLetter     = 4'd1;
  localparam logic [3:0] PosShortEnd   = 4'd6;
  localparam logic [3:0] PosLowSlash   = 4'd6;
  localparam logic [3:0] PosLowLetter  = 4'd7;
  localparam logic [3:0] PosLongEnd    = 4'd10;
  localparam logic [3:0] PosLastLow    = 4'd11;
  localparam logic [3:0] PosPairEnd    = 4'd12;

  localparam logic [3:0] UsedShort     = 4'd6;
  localparam logic [3:0] UsedLong      = 4'd10;
  localparam logic [3:0] UsedPair      = 4'd12;

  localparam logic [31:0] HighSurFirst = 32'h0000_D800;
  localparam logic [31:0] HighSurLast  = 32'h0000_DBFF;
  localparam logic [15:0] LowSurFirst  = 16'hDC00;
  localparam logic [15:0] LowSurLast   = 16'hDFFF;
  localparam logic [31:0] PlaneOne     = 32'h0001_0000;
  localparam logic [31:0] MaxOneByte   = 32'h0000_007F;
  localparam logic [31:0] MaxTwoByte   = 32'h0000_07FF;
  localparam logic [31:0] MaxThreeByte = 32'h0000_FFFF;
  localparam logic [31:0] MaxCodePoint = 32'h0010_FFFF;

  localparam logic [7:0] LeadTwo       = 8'hC0;
  localparam logic [7:0] LeadThree     = 8'hE0;
  localparam logic [7:0] LeadFour      = 8'hF0;
  localparam logic [7:0] ContMark      = 8'h80;

endpackage

>>> sv/uetu_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
interface uetu_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/unicode_escape_to_utf8.sv
// Top level of the Unicode escape to UTF-8 encoder.
// The block takes source text one character per word on the chars channel.
// A word with start_req set opens a candidate escape and latches space_left.
// Recognised forms are a backslash-u escape with four hex digits, a backslash-U
// escape with eight, and a high surrogate followed by a backslash-u low
// surrogate. When the outcome of a candidate is known, one word leaves on the
// codes channel: characters consumed (zero on failure), byte count and up to
// four UTF-8 bytes, unused bytes being zero.
// Every character is parsed in the cycle it is accepted, so one character is
// taken per cycle while chars.ready is high. A result word is held in the output
// register from the cycle after the character that completes it.
// The output register frees itself when the receiver takes its word, so
// chars.ready stays high while codes.ready is high; a stalled receiver holds
// the pending word and stops input only while that word waits.
// Reset is synchronous: it drops any parse under way and empties the output
// register.
module unicode_escape_to_utf8 (
  input logic         clk,
  input logic         rst,
  uetu_stream_if.sink   chars,
  uetu_stream_if.source codes
);

  logic        active;
  logic [3:0]  position;
  logic        long_form;
  logic [31:0] first_value;
  logic [15:0] second_value;
  logic [15:0] room;

  logic        active_next;
  logic [3:0]  position_next;
  logic        long_form_next;
  logic [31:0] first_value_next;
  logic [15:0] second_value_next;
  logic [15:0] room_next;

  logic                  out_valid;
  uetu_pkg::out_word_t   out_word;
  uetu_pkg::out_word_t   result_word;

  logic        emit;
  logic        emit_ok;
  logic [3:0]  emit_used;
  logic [31:0] emit_cp;

  logic        accept;

  assign chars.ready = !out_valid || codes.ready;
  assign accept      = chars.valid && chars.ready;
  assign codes.valid = out_valid;
  assign codes.data  = out_word;

  always_comb begin
    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [3:0]  limit;
    logic [3:0]  pos_inc;
    logic [31:0] fv_shift;
    logic [15:0] sv_shift;

    c = chars.data.char_byte;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_ok  = 1'b1;
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_ok  = 1'b1;
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok  = 1'b0;
      hex_val = 4'd0;
    end

    if (chars.data.start_req) begin
      active_next       = 1'b1;
      position_next     = uetu_pkg::PosBackslash;
      long_form_next    = 1'b0;
      first_value_next  = 32'd0;
      second_value_next = 16'd0;
      room_next         = chars.data.space_left;
    end else begin
      active_next       = active;
      position_next     = position;
      long_form_next    = long_form;
      first_value_next  = first_value;
      second_value_next = second_value;
      room_next         = room;
    end

    limit    = long_form_next ? uetu_pkg::PosLongEnd : uetu_pkg::PosShortEnd;
    pos_inc  = position_next + 4'd1;
    fv_shift = {first_value_next[27:0], hex_val};
    sv_shift = {second_value_next[11:0], hex_val};

    emit      = 1'b0;
    emit_ok   = 1'b0;
    emit_used = 4'd0;
    emit_cp   = 32'd0;

    if (active_next) begin
      if (position_next == uetu_pkg::PosBackslash) begin
        if (c != uetu_pkg::CharBackslash) begin
          emit = 1'b1;
        end else begin
          position_next = uetu_pkg::PosLetter;
        end
      end else if (position_next == uetu_pkg::PosLetter) begin
        if (c == uetu_pkg::CharLowerU) begin
          long_form_next = 1'b0;
          position_next  = 4'd2;
        end else if (c == uetu_pkg::CharUpperU) begin
          long_form_next = 1'b1;
          position_next  = 4'd2;
        end else begin
          emit = 1'b1;
        end
      end else if (position_next < limit) begin
        if (!hex_ok) begin
          emit = 1'b1;
        end else begin
          first_value_next = fv_shift;
          position_next    = pos_inc;
          if (long_form_next && pos_inc == uetu_pkg::PosLongEnd) begin
            emit      = 1'b1;
            emit_ok   = 1'b1;
            emit_used = uetu_pkg::UsedLong;
            emit_cp   = fv_shift;
          end else if (!long_form_next && pos_inc == uetu_pkg::PosShortEnd &&
                       !(fv_shift >= uetu_pkg::HighSurFirst &&
                         fv_shift <= uetu_pkg::HighSurLast)) begin
            emit      = 1'b1;
            emit_ok   = 1'b1;
            emit_used = uetu_pkg::UsedShort;
            emit_cp   = fv_shift;
          end
        end
      end else if (long_form_next || position_next > uetu_pkg::PosLastLow) begin
        active_next = 1'b0;
      end else if (position_next == uetu_pkg::PosLowSlash) begin
        if (c != uetu_pkg::CharBackslash) begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_used = uetu_pkg::UsedShort;
          emit_cp   = first_value_next;
        end else begin
          position_next = uetu_pkg::PosLowLetter;
        end
      end else if (position_next == uetu_pkg::PosLowLetter) begin
        if (c != uetu_pkg::CharLowerU) begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_used = uetu_pkg::UsedShort;
          emit_cp   = first_value_next;
        end else begin
          position_next = 4'd8;
        end
      end else begin
        if (!hex_ok) begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_used = uetu_pkg::UsedShort;
          emit_cp   = first_value_next;
        end else begin
          second_value_next = sv_shift;
          position_next     = pos_inc;
          if (pos_inc == uetu_pkg::PosPairEnd) begin
            emit = 1'b1;
            if (sv_shift >= uetu_pkg::LowSurFirst && sv_shift <= uetu_pkg::LowSurLast) begin
              emit_ok   = 1'b1;
              emit_used = uetu_pkg::UsedPair;
              emit_cp   = uetu_pkg::PlaneOne +
                          {12'd0, first_value_next[9:0], sv_shift[9:0]};
            end
          end
        end
      end
    end

    if (emit) begin
      active_next = 1'b0;
    end
  end

  always_comb begin
    logic [2:0] n;
    logic       ok;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;

    n  = 3'd0;
    b0 = 8'd0;
    b1 = 8'd0;
    b2 = 8'd0;
    b3 = 8'd0;
    if (emit_cp <= uetu_pkg::MaxOneByte) begin
      n  = 3'd1;
      b0 = emit_cp[7:0];
    end else if (emit_cp <= uetu_pkg::MaxTwoByte) begin
      n  = 3'd2;
      b0 = uetu_pkg::LeadTwo | {3'd0, emit_cp[10:6]};
      b1 = uetu_pkg::ContMark | {2'd0, emit_cp[5:0]};
    end else if (emit_cp <= uetu_pkg::MaxThreeByte) begin
      n  = 3'd3;
      b0 = uetu_pkg::LeadThree | {4'd0, emit_cp[15:12]};
      b1 = uetu_pkg::ContMark | {2'd0, emit_cp[11:6]};
      b2 = uetu_pkg::ContMark | {2'd0, emit_cp[5:0]};
    end else if (emit_cp <= uetu_pkg::MaxCodePoint) begin
      n  = 3'd4;
      b0 = uetu_pkg::LeadFour | {5'd0, emit_cp[20:18]};
      b1 = uetu_pkg::ContMark | {2'd0, emit_cp[17:12]};
      b2 = uetu_pkg::ContMark | {2'd0, emit_cp[11:6]};
      b3 = uetu_pkg::ContMark | {2'd0, emit_cp[5:0]};
    end

    ok = emit_ok && (n != 3'd0) && ({13'd0, n} + 16'd1 <= room_next);

    if (ok) begin
      result_word.consumed   = emit_used;
      result_word.byte_count = n;
      result_word.utf8_byte0 = b0;
      result_word.utf8_byte1 = b1;
      result_word.utf8_byte2 = b2;
      result_word.utf8_byte3 = b3;
    end else begin
      result_word.consumed   = 4'd0;
      result_word.byte_count = 3'd0;
      result_word.utf8_byte0 = 8'd0;
      result_word.utf8_byte1 = 8'd0;
      result_word.utf8_byte2 = 8'd0;
      result_word.utf8_byte3 = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      position     <= 4'd0;
      long_form    <= 1'b0;
      first_value  <= 32'd0;
      second_value <= 16'd0;
      room         <= 16'd0;
    end else if (accept) begin
      active       <= active_next;
      position     <= position_next;
      long_form    <= long_form_next;
      first_value  <= first_value_next;
      second_value <= second_value_next;
      room         <= room_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (codes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_word <= result_word;
    end
  end

endmodule
